>>> design/apsel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsel_pkg
// shared constants, codes and row layouts of the core-node priority selector
// ----------------------------------------------------------------------------
package apsel_pkg;

    localparam int ENTRIES     = 8;
    localparam int ID_SLOTS    = 4;
    localparam int SLICE_SLOTS = 8;

    localparam int ENTRY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_AW    = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
    localparam int SLICE_AW = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;

    localparam int SET_ID_W = 10;
    localparam int PTR_W    = 6;
    localparam int SLICE_W  = 9;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        MODE_FLAGS  = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_SLICE  = 2'd2,
        MODE_SELECT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_IDENT = 2'd0,
        KIND_SLICE = 2'd1,
        KIND_CONN  = 2'd2,
        KIND_PRES  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                valid;
        logic [SET_ID_W-1:0] set_id;
        logic [PTR_W-1:0]    ptr;
    } id_slot_t;

    typedef struct packed {
        logic                      valid;
        logic signed [SLICE_W-1:0] slice;
    } slice_slot_t;

    typedef id_slot_t    [ID_SLOTS-1:0]    id_row_t;
    typedef slice_slot_t [SLICE_SLOTS-1:0] slice_row_t;

    typedef struct packed {
        logic                      has_id;
        logic [SET_ID_W-1:0]       set_id;
        logic [PTR_W-1:0]          ptr;
        logic signed [SLICE_W-1:0] slice;
    } req_t;

    typedef struct packed {
        logic id_hit;
        logic slice_hit;
    } hit_t;

endpackage
`default_nettype wire

>>> design/apsel_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsel_ram
// simple dual-port row memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module apsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/apsel_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apsel_match
// compares one table row against the request, all slots side by side
// ----------------------------------------------------------------------------
module apsel_match (
    input  apsel_pkg::id_row_t    id_row,
    input  apsel_pkg::slice_row_t slice_row,
    input  apsel_pkg::req_t       req,
    output apsel_pkg::hit_t       hit
);

    import apsel_pkg::*;

    always_comb
    begin
        hit = '0;
        for (int s = 0; s < ID_SLOTS; s++)
        begin
            if (req.has_id && id_row[s].valid && id_row[s].set_id == req.set_id
                && id_row[s].ptr == req.ptr)
            begin
                hit.id_hit = 1'b1;
            end
        end
        for (int s = 0; s < SLICE_SLOTS; s++)
        begin
            // negative request means no slice
            if (!req.slice[SLICE_W-1] && slice_row[s].valid
                && slice_row[s].slice == req.slice)
            begin
                hit.slice_hit = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/amf_priority_selector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amf_priority_selector_core
// core-node table with priority selection by identity, slice, connection
// ----------------------------------------------------------------------------
// Each input transaction is taken one at a time. A flag write completes as it
// is taken, an identity or slice slot write in a further modify step (the
// entry's row is read from its memory as the write is taken, the slot is
// replaced and the row written back). A select reads the first row as it is
// taken, then scans one table row per cycle from the identity and slice row
// memories, then picks the result once the output register is free; the
// result is one output transaction. A finished result waits in the output
// register while the next transaction is taken. Slot memories come out of
// reset with every row reading as empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module amf_priority_selector_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, slot_index, entry_present, entry_connected, slot_valid,
    // set_id, node_pointer, slice_type, has_identity, zero pad
    input  logic [apsel_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [apsel_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // selected_entry, zero pad
    output logic [apsel_pkg::M_TDATA_W-1:0] m_tdata,
    // found, match_kind
    output logic [apsel_pkg::M_TUSER_W-1:0] m_tuser
);

    import apsel_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_MOD,
        S_SCAN,
        S_RESULT
    } state_t;

    // input unpacking
    logic [2:0]                in_entry;
    logic [2:0]                in_slot;
    logic                      in_present;
    logic                      in_connected;
    logic                      in_slot_valid;
    logic [SET_ID_W-1:0]       in_set_id;
    logic [PTR_W-1:0]          in_ptr;
    logic signed [SLICE_W-1:0] in_slice;
    logic                      in_has_id;
    mode_t                     in_mode;

    assign in_entry      = s_tdata[2:0];
    assign in_slot       = s_tdata[5:3];
    assign in_present    = s_tdata[6];
    assign in_connected  = s_tdata[7];
    assign in_slot_valid = s_tdata[8];
    assign in_set_id     = s_tdata[18:9];
    assign in_ptr        = s_tdata[24:19];
    assign in_slice      = s_tdata[33:25];
    assign in_has_id     = s_tdata[34];
    assign in_mode       = mode_t'(s_tuser);

    state_t                    state_reg;
    mode_t                     mode_reg;
    logic [ENTRY_AW-1:0]       ent_reg;
    logic [2:0]                slot_reg;
    logic                      wr_valid_reg;
    logic [SET_ID_W-1:0]       set_id_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic signed [SLICE_W-1:0] slice_reg;
    logic                      has_id_reg;
    logic [ENTRY_AW-1:0]       scan_reg;
    logic [ENTRIES-1:0]        present_reg;
    logic [ENTRIES-1:0]        connected_reg;
    logic [ENTRIES-1:0]        id_row_valid_reg;
    logic [ENTRIES-1:0]        sl_row_valid_reg;
    logic                      id_hit_reg;
    logic [ENTRY_AW-1:0]       id_idx_reg;
    logic                      sl_hit_reg;
    logic [ENTRY_AW-1:0]       sl_idx_reg;
    logic                      conn_hit_reg;
    logic [ENTRY_AW-1:0]       conn_idx_reg;
    logic                      pres_hit_reg;
    logic [ENTRY_AW-1:0]       pres_idx_reg;
    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [2:0]                out_entry_reg;
    kind_t                     out_kind_reg;

    logic                s_accept;
    logic                ent_ok;
    logic                id_slot_ok;
    logic                sl_slot_ok;
    logic                scan_last;
    logic                out_free;
    logic                rd_en;
    logic [ENTRY_AW-1:0] rd_addr;
    logic                id_we;
    logic                sl_we;
    id_row_t             id_rdata;
    slice_row_t          sl_rdata;
    id_row_t             id_row;
    slice_row_t          sl_row;
    id_row_t             id_wdata;
    slice_row_t          sl_wdata;
    id_row_t             id_base;
    slice_row_t          sl_base;
    req_t                req;
    hit_t                hit;
    logic                pres_e;
    logic                conn_e;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign ent_ok     = int'(in_entry) < ENTRIES;
    assign id_slot_ok = int'(in_slot) < ID_SLOTS;
    assign sl_slot_ok = int'(in_slot) < SLICE_SLOTS;
    assign scan_last  = (scan_reg == ENTRY_AW'(ENTRIES - 1));
    assign out_free   = !out_valid_reg || m_tready;

    assign req.has_id = has_id_reg;
    assign req.set_id = set_id_reg;
    assign req.ptr    = ptr_reg;
    assign req.slice  = slice_reg;

    // rows never written read as empty
    assign id_row = id_row_valid_reg[scan_reg] ? id_rdata : '0;
    assign sl_row = sl_row_valid_reg[scan_reg] ? sl_rdata : '0;

    assign pres_e = present_reg[scan_reg];
    assign conn_e = pres_e && connected_reg[scan_reg];

    // memory access control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ENTRY_AW'(in_entry);
        if (state_reg == S_IDLE)
        begin
            rd_en = s_accept;
            if (in_mode == MODE_SELECT)
            begin
                rd_addr = '0;
            end
        end
        else if (state_reg == S_SCAN)
        begin
            rd_en   = !scan_last;
            rd_addr = scan_reg + 1'b1;
        end
    end

    assign id_we = (state_reg == S_WR_MOD) && (mode_reg == MODE_IDENT);
    assign sl_we = (state_reg == S_WR_MOD) && (mode_reg == MODE_SLICE);

    // read-modify-write of one slot in the entry's row
    always_comb
    begin
        id_base  = id_row_valid_reg[ent_reg] ? id_rdata : '0;
        sl_base  = sl_row_valid_reg[ent_reg] ? sl_rdata : '0;
        id_wdata = id_base;
        sl_wdata = sl_base;
        id_wdata[ID_AW'(slot_reg)] = '{valid: wr_valid_reg, set_id: set_id_reg, ptr: ptr_reg};
        sl_wdata[SLICE_AW'(slot_reg)] = '{valid: wr_valid_reg, slice: slice_reg};
    end

    apsel_ram #(
        .WIDTH ($bits(id_row_t)),
        .DEPTH (ENTRIES)
    ) u_id_ram (
        .clk   (clk),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (id_rdata),
        .we    (id_we),
        .waddr (ent_reg),
        .wdata (id_wdata)
    );

    apsel_ram #(
        .WIDTH ($bits(slice_row_t)),
        .DEPTH (ENTRIES)
    ) u_slice_ram (
        .clk   (clk),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (sl_rdata),
        .we    (sl_we),
        .waddr (ent_reg),
        .wdata (sl_wdata)
    );

    apsel_match u_match (
        .id_row    (id_row),
        .slice_row (sl_row),
        .req       (req),
        .hit       (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_FLAGS;
            ent_reg          <= '0;
            slot_reg         <= '0;
            wr_valid_reg     <= 1'b0;
            set_id_reg       <= '0;
            ptr_reg          <= '0;
            slice_reg        <= '0;
            has_id_reg       <= 1'b0;
            scan_reg         <= '0;
            present_reg      <= '0;
            connected_reg    <= '0;
            id_row_valid_reg <= '0;
            sl_row_valid_reg <= '0;
            id_hit_reg       <= 1'b0;
            id_idx_reg       <= '0;
            sl_hit_reg       <= 1'b0;
            sl_idx_reg       <= '0;
            conn_hit_reg     <= 1'b0;
            conn_idx_reg     <= '0;
            pres_hit_reg     <= 1'b0;
            pres_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_found_reg    <= 1'b0;
            out_entry_reg    <= '0;
            out_kind_reg     <= KIND_IDENT;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        mode_reg     <= in_mode;
                        ent_reg      <= ENTRY_AW'(in_entry);
                        slot_reg     <= in_slot;
                        wr_valid_reg <= in_slot_valid;
                        set_id_reg   <= in_set_id;
                        ptr_reg      <= in_ptr;
                        slice_reg    <= in_slice;
                        has_id_reg   <= in_has_id;
                        unique case (in_mode)
                            MODE_FLAGS:
                            begin
                                if (ent_ok)
                                begin
                                    present_reg[ENTRY_AW'(in_entry)]   <= in_present;
                                    connected_reg[ENTRY_AW'(in_entry)] <= in_connected;
                                end
                            end
                            MODE_IDENT:
                            begin
                                if (ent_ok && id_slot_ok)
                                begin
                                    state_reg <= S_WR_MOD;
                                end
                            end
                            MODE_SLICE:
                            begin
                                if (ent_ok && sl_slot_ok)
                                begin
                                    state_reg <= S_WR_MOD;
                                end
                            end
                            MODE_SELECT:
                            begin
                                scan_reg     <= '0;
                                id_hit_reg   <= 1'b0;
                                sl_hit_reg   <= 1'b0;
                                conn_hit_reg <= 1'b0;
                                pres_hit_reg <= 1'b0;
                                state_reg    <= S_SCAN;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_WR_MOD:
                begin
                    if (mode_reg == MODE_IDENT)
                    begin
                        id_row_valid_reg[ent_reg] <= 1'b1;
                    end
                    else
                    begin
                        sl_row_valid_reg[ent_reg] <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end

                S_SCAN:
                begin
                    if (pres_e && !pres_hit_reg)
                    begin
                        pres_hit_reg <= 1'b1;
                        pres_idx_reg <= scan_reg;
                    end
                    if (conn_e && !conn_hit_reg)
                    begin
                        conn_hit_reg <= 1'b1;
                        conn_idx_reg <= scan_reg;
                    end
                    if (conn_e && hit.id_hit && !id_hit_reg)
                    begin
                        id_hit_reg <= 1'b1;
                        id_idx_reg <= scan_reg;
                    end
                    if (conn_e && hit.slice_hit && !sl_hit_reg)
                    begin
                        sl_hit_reg <= 1'b1;
                        sl_idx_reg <= scan_reg;
                    end
                    if (scan_last)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= 1'b1;
                        priority if (id_hit_reg)
                        begin
                            out_entry_reg <= 3'(id_idx_reg);
                            out_kind_reg  <= KIND_IDENT;
                        end
                        else if (sl_hit_reg)
                        begin
                            out_entry_reg <= 3'(sl_idx_reg);
                            out_kind_reg  <= KIND_SLICE;
                        end
                        else if (conn_hit_reg)
                        begin
                            out_entry_reg <= 3'(conn_idx_reg);
                            out_kind_reg  <= KIND_CONN;
                        end
                        else if (pres_hit_reg)
                        begin
                            out_entry_reg <= 3'(pres_idx_reg);
                            out_kind_reg  <= KIND_PRES;
                        end
                        else
                        begin
                            out_found_reg <= 1'b0;
                            out_entry_reg <= '0;
                            out_kind_reg  <= KIND_IDENT;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 3){1'b0}}, out_entry_reg};
    assign m_tuser  = {out_kind_reg, out_found_reg};

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_entry_reg == '0 && out_kind_reg == KIND_IDENT)
        else $error("not-found result carries an entry or kind");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> int'(scan_reg) < ENTRIES)
        else $error("scan pointer beyond the table");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESULT)
        else $error("result raised outside the result step");

    a_single_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        id_we || sl_we |-> state_reg == S_WR_MOD && !(id_we && sl_we))
        else $error("row write-back outside the modify step");

    a_conn_after_pres: assert property (@(posedge clk) disable iff (!rst_n)
        conn_hit_reg |-> pres_hit_reg && pres_idx_reg <= conn_idx_reg)
        else $error("connected pick without an earlier present pick");

endmodule
`default_nettype wire

>>> test/amf_priority_selector_core_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amf_priority_selector_core_test
// stream-level self-checking bench for the core-node priority selector
// ----------------------------------------------------------------------------
// Items from a pending queue are driven onto the input stream. Every accepted
// write transaction updates a local copy of the node table, and each select
// adds its expected pick to a queue that the output monitor checks field by
// field. A directed opening covers the special cases, then a long receiver
// hold-off. Random phases follow, with different sender and receiver idling.
// ----------------------------------------------------------------------------
module amf_priority_selector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import apsel_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        mode_t                     mode;
        logic [2:0]                entry;
        logic [2:0]                slot;
        logic                      present;
        logic                      connected;
        logic                      slot_valid;
        logic [SET_ID_W-1:0]       set_id;
        logic [PTR_W-1:0]          ptr;
        logic signed [SLICE_W-1:0] slice;
        logic                      has_id;
    } node_op_t;

    typedef struct {
        logic       found;
        logic [2:0] entry;
        kind_t      kind;
    } node_pick_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    node_op_t   pending_q[$];
    node_pick_t pick_q[$];
    node_op_t   drv_op;

    // local copy of the node table
    logic                      tbl_present[ENTRIES];
    logic                      tbl_connected[ENTRIES];
    logic                      id_valid[ENTRIES][ID_SLOTS];
    logic [SET_ID_W-1:0]       id_set[ENTRIES][ID_SLOTS];
    logic [PTR_W-1:0]          id_ptr[ENTRIES][ID_SLOTS];
    logic                      sl_valid[ENTRIES][SLICE_SLOTS];
    logic signed [SLICE_W-1:0] sl_type[ENTRIES][SLICE_SLOTS];

    logic [SET_ID_W-1:0]       sid_pool[4];
    logic [PTR_W-1:0]          ptr_pool[4];
    logic signed [SLICE_W-1:0] slice_pool[4];

    int idle_pct = 0;
    int stall_pct = 0;
    int offered_cnt = 0;
    int taken_cnt = 0;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    amf_priority_selector_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic node_op_t make_op(mode_t mode, int entry, int slot, bit present,
                                         bit connected, bit slot_valid, int set_id,
                                         int ptr, int slice, bit has_id);
        node_op_t op;
        op.mode       = mode;
        op.entry      = 3'(entry);
        op.slot       = 3'(slot);
        op.present    = present;
        op.connected  = connected;
        op.slot_valid = slot_valid;
        op.set_id     = SET_ID_W'(set_id);
        op.ptr        = PTR_W'(ptr);
        op.slice      = SLICE_W'(slice);
        op.has_id     = has_id;
        return op;
    endfunction

    function automatic node_op_t random_op();
        node_op_t op;
        int       r;
        op.entry      = 3'($urandom);
        op.slot       = 3'($urandom);
        op.present    = 1'($urandom);
        op.connected  = 1'($urandom);
        op.slot_valid = 1'($urandom);
        op.set_id     = SET_ID_W'($urandom);
        op.ptr        = PTR_W'($urandom);
        op.slice      = SLICE_W'($urandom);
        op.has_id     = 1'($urandom);
        r = $urandom_range(99);
        if (r < 15)
        begin
            op.mode      = MODE_FLAGS;
            op.present   = ($urandom_range(9) != 0);
            op.connected = ($urandom_range(2) != 0);
        end
        else if (r < 40)
        begin
            op.mode       = MODE_IDENT;
            op.slot_valid = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 80)
                op.slot = 3'($urandom_range(ID_SLOTS - 1));
            if ($urandom_range(99) < 85)
            begin
                op.set_id = sid_pool[$urandom_range(3)];
                op.ptr    = ptr_pool[$urandom_range(3)];
            end
        end
        else if (r < 65)
        begin
            op.mode       = MODE_SLICE;
            op.slot_valid = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 80)
                op.slice = slice_pool[$urandom_range(3)];
        end
        else
        begin
            op.mode   = MODE_SELECT;
            op.has_id = ($urandom_range(99) < 60);
            if ($urandom_range(99) < 85)
            begin
                op.set_id = sid_pool[$urandom_range(3)];
                op.ptr    = ptr_pool[$urandom_range(3)];
            end
            r = $urandom_range(99);
            if (r < 70)
                op.slice = slice_pool[$urandom_range(3)];
            else if (r < 85)
                op.slice = SLICE_W'(-$signed($urandom_range(256, 1)));
        end
        return op;
    endfunction

    function automatic void apply_write(node_op_t op);
        if (op.entry < ENTRIES)
        begin
            case (op.mode)
                MODE_FLAGS:
                begin
                    tbl_present[op.entry]   = op.present;
                    tbl_connected[op.entry] = op.connected;
                end
                MODE_IDENT:
                    if (op.slot < ID_SLOTS)
                    begin
                        id_valid[op.entry][op.slot] = op.slot_valid;
                        id_set[op.entry][op.slot]   = op.set_id;
                        id_ptr[op.entry][op.slot]   = op.ptr;
                    end
                MODE_SLICE:
                    if (op.slot < SLICE_SLOTS)
                    begin
                        sl_valid[op.entry][op.slot] = op.slot_valid;
                        sl_type[op.entry][op.slot]  = op.slice;
                    end
                default: ;
            endcase
        end
    endfunction

    function automatic node_pick_t pick_node(node_op_t req);
        node_pick_t res;
        int         by_id;
        int         by_slice;
        int         any_conn;
        int         any_pres;
        bit         id_hit;
        bit         slice_hit;
        by_id    = -1;
        by_slice = -1;
        any_conn = -1;
        any_pres = -1;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (tbl_present[e])
            begin
                if (any_pres < 0)
                    any_pres = e;
                if (tbl_connected[e])
                begin
                    if (any_conn < 0)
                        any_conn = e;
                    id_hit    = 1'b0;
                    slice_hit = 1'b0;
                    for (int s = 0; s < ID_SLOTS; s++)
                        if (id_valid[e][s] && id_set[e][s] == req.set_id
                            && id_ptr[e][s] == req.ptr)
                            id_hit = 1'b1;
                    // negative request means no slice
                    if (!req.slice[SLICE_W-1])
                        for (int s = 0; s < SLICE_SLOTS; s++)
                            if (sl_valid[e][s] && sl_type[e][s] == req.slice)
                                slice_hit = 1'b1;
                    if (req.has_id && id_hit && by_id < 0)
                        by_id = e;
                    if (slice_hit && by_slice < 0)
                        by_slice = e;
                end
            end
        end
        res.found = 1'b1;
        res.entry = '0;
        res.kind  = KIND_IDENT;
        if (by_id >= 0)
            res.entry = 3'(by_id);
        else if (by_slice >= 0)
        begin
            res.entry = 3'(by_slice);
            res.kind  = KIND_SLICE;
        end
        else if (any_conn >= 0)
        begin
            res.entry = 3'(any_conn);
            res.kind  = KIND_CONN;
        end
        else if (any_pres >= 0)
        begin
            res.entry = 3'(any_pres);
            res.kind  = KIND_PRES;
        end
        else
            res.found = 1'b0;
        return res;
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && taken_cnt != offered_cnt))
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                drv_op = pending_q.pop_front();
                s_tdata <= {5'b0, drv_op.has_id, drv_op.slice, drv_op.ptr, drv_op.set_id,
                            drv_op.slot_valid, drv_op.connected, drv_op.present,
                            drv_op.slot, drv_op.entry};
                s_tuser <= drv_op.mode;
                s_tvalid <= 1'b1;
                offered_cnt++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output ready, with long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // transaction monitor
    always @(posedge clk)
    begin
        node_pick_t exp_pick;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                taken_cnt++;
                if (drv_op.mode == MODE_SELECT)
                    pick_q.push_back(pick_node(drv_op));
                else
                    apply_write(drv_op);
            end
            if (m_tvalid && m_tready)
            begin
                if (pick_q.size() == 0)
                begin
                    $error("result transaction with no pick expected");
                    fail_cnt++;
                end
                else
                begin
                    exp_pick = pick_q.pop_front();
                    if (m_tuser[0] !== exp_pick.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_pick.found, m_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_tdata[2:0] !== exp_pick.entry)
                    begin
                        $error("selected_entry: expected %0d, got %0d",
                               exp_pick.entry, m_tdata[2:0]);
                        fail_cnt++;
                    end
                    if (m_tuser[2:1] !== exp_pick.kind)
                    begin
                        $error("match_kind: expected %0d, got %0d",
                               exp_pick.kind, m_tuser[2:1]);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || pick_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            tbl_present[e]   = 1'b0;
            tbl_connected[e] = 1'b0;
            for (int s = 0; s < ID_SLOTS; s++)
            begin
                id_valid[e][s] = 1'b0;
                id_set[e][s]   = '0;
                id_ptr[e][s]   = '0;
            end
            for (int s = 0; s < SLICE_SLOTS; s++)
            begin
                sl_valid[e][s] = 1'b0;
                sl_type[e][s]  = '0;
            end
        end
        sid_pool   = '{10'd0, 10'd1023, 10'($urandom), 10'($urandom)};
        ptr_pool   = '{6'd0, 6'd63, 6'($urandom), 6'($urandom)};
        slice_pool = '{9'sd0, 9'sd255, 9'($urandom_range(255)), 9'($urandom_range(255))};

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // empty table, then connected without presence
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_q.push_back(make_op(MODE_FLAGS, 7, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 1023, 63, 255, 1));
        // present only, then connected
        pending_q.push_back(make_op(MODE_FLAGS, 5, 0, 1, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, -1, 0));
        pending_q.push_back(make_op(MODE_FLAGS, 6, 0, 1, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 255, 0));
        // slice match and negative slice
        pending_q.push_back(make_op(MODE_SLICE, 6, 7, 0, 0, 1, 0, 0, 255, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 255, 0));
        pending_q.push_back(make_op(MODE_SLICE, 3, 0, 0, 0, 1, 0, 0, -1, 0));
        pending_q.push_back(make_op(MODE_FLAGS, 3, 0, 1, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, -1, 0));
        // identity match, and identity skipped
        pending_q.push_back(make_op(MODE_IDENT, 6, 3, 0, 0, 1, 1023, 63, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 1023, 63, 255, 1));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 1023, 63, 255, 0));
        // out-of-range slot and invalid slot
        pending_q.push_back(make_op(MODE_IDENT, 0, 4, 0, 0, 1, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_IDENT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SLICE, 0, 7, 0, 0, 1, 0, 0, -256, 0));
        pending_q.push_back(make_op(MODE_FLAGS, 0, 0, 1, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, -256, 1));
        // presence cleared and restored keeps the slots
        pending_q.push_back(make_op(MODE_FLAGS, 6, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_FLAGS, 6, 0, 1, 1, 0, 0, 0, 0, 0));
        pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 1023, 63, 0, 1));
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_req++;
        for (int i = 0; i < 30; i++)
            pending_q.push_back(make_op(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0,
                                        $urandom_range(255), 1'($urandom_range(1))));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            for (int i = 0; i < 440; i++)
                pending_q.push_back(random_op());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pick_q.size() != 0)
        begin
            $error("%0d expected picks never arrived", pick_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
